/* design/tssm_pkg.sv */
// Package for the tensor scalar min/max stream: beat types, field widths,
// mode and register codes, and the tuple component selection helpers.
// No dependencies.
package tssm_pkg;

    localparam int CW        = 32;        // component width, Q16.16
    localparam int NUM_COMPS = 9;
    localparam int NUM_LANES = 6;
    localparam int OPW       = CW + 1;    // lane operand (differences need one more bit)
    localparam int SQW       = 2 * OPW;   // lane square
    localparam int RADW      = SQW + 2;   // radicand after summing and scaling
    localparam int ROOTW     = CW - 1;    // root bits below the saturation point
    localparam int IDXW      = 24;
    localparam int CNTW      = 25;

    localparam logic signed [CW-1:0] Q_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] Q_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CNTW-1:0]      COUNT_MAX = {CNTW{1'b1}};

    // derivation modes
    localparam logic [1:0] MODE_SINGLE = 2'd0;
    localparam logic [1:0] MODE_MAG    = 2'd1;
    localparam logic [1:0] MODE_VM     = 2'd2;

    // configuration register indices
    localparam logic [2:0] CFG_MODE = 3'd0;
    localparam logic [2:0] CFG_SEL  = 3'd1;
    localparam logic [2:0] CFG_XX   = 3'd2;
    localparam logic [2:0] CFG_YY   = 3'd3;
    localparam logic [2:0] CFG_ZZ   = 3'd4;
    localparam logic [2:0] CFG_XY   = 3'd5;
    localparam logic [2:0] CFG_YZ   = 3'd6;
    localparam logic [2:0] CFG_ZX   = 3'd7;

    // stress tensor slots
    localparam int T_XX = 0;
    localparam int T_YY = 1;
    localparam int T_ZZ = 2;
    localparam int T_XY = 3;
    localparam int T_YZ = 4;
    localparam int T_ZX = 5;

    typedef logic signed [CW-1:0] t_comp_arr [NUM_COMPS];

    typedef struct packed {
        logic signed [CW-1:0] comp0;
        logic signed [CW-1:0] comp1;
        logic signed [CW-1:0] comp2;
        logic signed [CW-1:0] comp3;
        logic signed [CW-1:0] comp4;
        logic signed [CW-1:0] comp5;
        logic signed [CW-1:0] comp6;
        logic signed [CW-1:0] comp7;
        logic signed [CW-1:0] comp8;
        logic [NUM_COMPS-1:0] nonfinite_mask;
        logic                 last_tuple;
    } t_in_beat;

    typedef struct packed {
        logic signed [CW-1:0] derived_value;
        logic                 value_valid;
        logic [IDXW-1:0]      tuple_index;
        logic signed [CW-1:0] running_minimum;
        logic signed [CW-1:0] running_maximum;
        logic [IDXW-1:0]      minimum_index;
        logic [IDXW-1:0]      maximum_index;
        logic [CNTW-1:0]      ignored_count;
        logic                 no_valid_value;
        logic                 last_result;
    } t_out_beat;

    // root unit status
    typedef struct packed {
        logic busy;
        logic done;
    } t_root_stat;

    // component usable: index in range and finite
    function automatic logic pick_ok(logic [NUM_COMPS-1:0] mask, logic [3:0] idx);
        logic ok;
        ok = 1'b0;
        for (int i = 0; i < NUM_COMPS; i++) begin
            if (idx == 4'(i)) ok = !mask[i];
        end
        return ok;
    endfunction

    function automatic logic signed [CW-1:0] pick_val(t_comp_arr c, logic [3:0] idx);
        logic signed [CW-1:0] v;
        v = '0;
        for (int i = 0; i < NUM_COMPS; i++) begin
            if (idx == 4'(i)) v = c[i];
        end
        return v;
    endfunction

endpackage

/* design/tssm_if.sv */
// Stream channel interfaces for the tensor scalar min/max stream.
// Depends on tssm_pkg for the beat types.
interface tssm_in_if import tssm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tssm_out_if import tssm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/tensor_scalar_min_max_stream.sv */
// Tensor scalar min/max stream, top level. One tuple at a time.
// Single-component or invalid tuples go from S_IDLE to S_DONE; a root tuple passes
// S_SQ (square lanes), S_SUM (merge) and S_ROOT (31-step bit-serial root) first. A new
// tuple is taken only in S_IDLE, after the last result has moved to the output register.
// Reset (synchronous, active low) restores configuration defaults and clears
// statistics; the statistics also clear after the beat marked last.
module tensor_scalar_min_max_stream import tssm_pkg::*; #(
    parameter int MAX_TUPLES = 16777216
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tssm_in_if.sink     in_ch,
    tssm_out_if.source  out_ch,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SQ   = 5'b00010,
        S_SUM  = 5'b00100,
        S_ROOT = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [1:0] r_mode;
    logic [3:0] r_sel;
    logic [3:0] r_tidx [NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SINGLE;
            r_sel  <= '0;
            for (int i = 0; i < NUM_LANES; i++) r_tidx[i] <= 4'(i);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MODE: r_mode         <= i_cfg_data[1:0];
                CFG_SEL:  r_sel          <= i_cfg_data;
                CFG_XX:   r_tidx[T_XX]   <= i_cfg_data;
                CFG_YY:   r_tidx[T_YY]   <= i_cfg_data;
                CFG_ZZ:   r_tidx[T_ZZ]   <= i_cfg_data;
                CFG_XY:   r_tidx[T_XY]   <= i_cfg_data;
                CFG_YZ:   r_tidx[T_YZ]   <= i_cfg_data;
                CFG_ZX:   r_tidx[T_ZX]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input beat decode
    t_comp_arr                 comps;
    logic                      accept;
    logic                      sel_ok, mag_ok, vm_ok;
    logic                      beat_valid, beat_root;
    logic signed [CW-1:0]      t_val [NUM_LANES];
    logic signed [OPW-1:0]     ops   [NUM_LANES];

    assign in_ch.ready = (r_state == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb begin
        comps[0] = in_ch.data.comp0;
        comps[1] = in_ch.data.comp1;
        comps[2] = in_ch.data.comp2;
        comps[3] = in_ch.data.comp3;
        comps[4] = in_ch.data.comp4;
        comps[5] = in_ch.data.comp5;
        comps[6] = in_ch.data.comp6;
        comps[7] = in_ch.data.comp7;
        comps[8] = in_ch.data.comp8;
        sel_ok = pick_ok(in_ch.data.nonfinite_mask, r_sel);
        mag_ok = (in_ch.data.nonfinite_mask[2:0] == 3'b000);
        vm_ok  = 1'b1;
        for (int i = 0; i < NUM_LANES; i++) begin
            vm_ok    = vm_ok && pick_ok(in_ch.data.nonfinite_mask, r_tidx[i]);
            t_val[i] = pick_val(comps, r_tidx[i]);
        end
        case (r_mode)
            MODE_SINGLE: begin beat_valid = sel_ok; beat_root = 1'b0;   end
            MODE_MAG:    begin beat_valid = mag_ok; beat_root = mag_ok; end
            MODE_VM:     begin beat_valid = vm_ok;  beat_root = vm_ok;  end
            default:     begin beat_valid = 1'b0;   beat_root = 1'b0;   end
        endcase
        // lane operands
        if (r_mode == MODE_VM) begin
            ops[0] = OPW'(t_val[T_XX]) - OPW'(t_val[T_YY]);
            ops[1] = OPW'(t_val[T_YY]) - OPW'(t_val[T_ZZ]);
            ops[2] = OPW'(t_val[T_ZZ]) - OPW'(t_val[T_XX]);
            ops[3] = OPW'(t_val[T_XY]);
            ops[4] = OPW'(t_val[T_YZ]);
            ops[5] = OPW'(t_val[T_ZX]);
        end else begin
            ops[0] = OPW'(comps[0]);
            ops[1] = OPW'(comps[1]);
            ops[2] = OPW'(comps[2]);
            ops[3] = '0;
            ops[4] = '0;
            ops[5] = '0;
        end
    end

    // item registers
    logic signed [OPW-1:0] r_ops [NUM_LANES];
    logic signed [CW-1:0]  r_val;
    logic                  r_valid;
    logic                  r_last;
    logic                  r_vm;
    logic                  r_out_valid;
    logic                  out_load;
    t_root_stat            root_stat;
    logic [CW-1:0]         root_val;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < NUM_LANES; i++) r_ops[i] <= ops[i];
            r_val   <= (beat_valid && !beat_root) ? pick_val(comps, r_sel) : '0;
            r_valid <= beat_valid;
            r_last  <= in_ch.data.last_tuple;
            r_vm    <= (r_mode == MODE_VM);
        end else if (r_state == S_ROOT && root_stat.done) begin
            r_val <= root_val;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = beat_root ? S_SQ : S_DONE;
            S_SQ:   n_state = S_SUM;
            S_SUM:  n_state = S_ROOT;
            S_ROOT: if (root_stat.done) n_state = S_DONE;
            S_DONE: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // squaring lanes, merge and root unit
    logic [SQW-1:0]  squares [NUM_LANES];
    logic [RADW-1:0] radicand;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        tssm_lane u_lane (
            .i_clk     (i_clk),
            .i_load    (r_state == S_SQ),
            .i_operand (r_ops[g]),
            .o_square  (squares[g])
        );
    end

    tssm_merge u_merge (
        .i_squares  (squares),
        .i_vm       (r_vm),
        .o_radicand (radicand)
    );

    tssm_root u_root (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_SUM),
        .i_radicand (radicand),
        .o_stat     (root_stat),
        .o_root     (root_val)
    );

    // statistics, updated as the result moves into the output register
    logic [IDXW-1:0]      r_tcount;
    logic signed [CW-1:0] r_min, r_max;
    logic [IDXW-1:0]      r_min_pos, r_max_pos;
    logic [CNTW-1:0]      r_ign;
    logic                 r_seen;
    logic signed [CW-1:0] n_min, n_max;
    logic [IDXW-1:0]      n_min_pos, n_max_pos;
    logic [CNTW-1:0]      n_ign;
    logic                 n_seen;
    logic [IDXW:0]        tcount_inc;
    t_out_beat            r_out;

    assign out_load   = (r_state == S_DONE) && (!r_out_valid || out_ch.ready);
    assign tcount_inc = (IDXW+1)'(r_tcount) + 1'b1;

    always_comb begin
        n_min     = r_min;
        n_max     = r_max;
        n_min_pos = r_min_pos;
        n_max_pos = r_max_pos;
        n_ign     = r_ign;
        n_seen    = r_seen;
        if (r_valid) begin
            if (!r_seen || r_val < r_min) begin
                n_min     = r_val;
                n_min_pos = r_tcount;
            end
            if (!r_seen || r_val > r_max) begin
                n_max     = r_val;
                n_max_pos = r_tcount;
            end
            n_seen = 1'b1;
        end else if (r_ign != COUNT_MAX) begin
            n_ign = r_ign + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcount  <= '0;
            r_min     <= Q_MAX;
            r_max     <= Q_MIN;
            r_min_pos <= '0;
            r_max_pos <= '0;
            r_ign     <= '0;
            r_seen    <= 1'b0;
        end else if (out_load) begin
            if (r_last) begin
                r_tcount  <= '0;
                r_min     <= Q_MAX;
                r_max     <= Q_MIN;
                r_min_pos <= '0;
                r_max_pos <= '0;
                r_ign     <= '0;
                r_seen    <= 1'b0;
            end else begin
                r_tcount  <= (tcount_inc >= (IDXW+1)'(MAX_TUPLES)) ? '0 : tcount_inc[IDXW-1:0];
                r_min     <= n_min;
                r_max     <= n_max;
                r_min_pos <= n_min_pos;
                r_max_pos <= n_max_pos;
                r_ign     <= n_ign;
                r_seen    <= n_seen;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.derived_value   <= r_val;
            r_out.value_valid     <= r_valid;
            r_out.tuple_index     <= r_tcount;
            r_out.running_minimum <= n_min;
            r_out.running_maximum <= n_max;
            r_out.minimum_index   <= n_min_pos;
            r_out.maximum_index   <= n_max_pos;
            r_out.ignored_count   <= n_ign;
            r_out.no_valid_value  <= !n_seen;
            r_out.last_result     <= r_last;
        end
    end

    assign out_ch.valid = r_out_valid;
    assign out_ch.data  = r_out;

    // checks
    a_root_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !root_stat.busy)
        else $error("root unit busy while block idle");

    a_done_in_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        root_stat.done |-> (r_state == S_ROOT))
        else $error("root finished outside root state");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> (r_min <= r_max))
        else $error("running minimum above running maximum");

    a_no_valid_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.data.no_valid_value) |->
            (out_ch.data.running_minimum == Q_MAX && out_ch.data.minimum_index == '0))
        else $error("statistics moved without a valid value");

endmodule

/* design/tssm_lane.sv */
// One squaring lane: registered square of a signed operand's magnitude.
// Depends on tssm_pkg.
module tssm_lane import tssm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic signed [OPW-1:0] i_operand,
    output logic [SQW-1:0]        o_square
);
    logic [OPW-1:0] mag;
    logic [SQW-1:0] r_sq;

    // magnitude fits OPW bits unsigned, even for the most negative value
    assign mag = i_operand[OPW-1] ? OPW'(~i_operand + 1'b1) : OPW'(i_operand);

    always_ff @(posedge i_clk) begin
        if (i_load) r_sq <= SQW'(mag) * SQW'(mag);
    end

    assign o_square = r_sq;
endmodule

/* design/tssm_merge.sv */
// Merging stage: combines the lane squares into the root radicand.
// Depends on tssm_pkg.
module tssm_merge import tssm_pkg::*; (
    input  logic [SQW-1:0]  i_squares [NUM_LANES],
    input  logic            i_vm,
    output logic [RADW-1:0] o_radicand
);
    logic [RADW-1:0] normal_sum;
    logic [RADW-1:0] shear_sum;

    always_comb begin
        normal_sum = RADW'(i_squares[0]) + RADW'(i_squares[1]) + RADW'(i_squares[2]);
        shear_sum  = RADW'(i_squares[3]) + RADW'(i_squares[4]) + RADW'(i_squares[5]);
        // von Mises: half the normal part (always even) plus three times shear
        if (i_vm) o_radicand = (normal_sum >> 1) + shear_sum + (shear_sum << 1);
        else      o_radicand = normal_sum;
    end
endmodule

/* design/tssm_root.sv */
// Bit-serial floor square root, one root bit per cycle, with saturation.
// Depends on tssm_pkg.
module tssm_root import tssm_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [RADW-1:0] i_radicand,
    output t_root_stat      o_stat,
    output logic [CW-1:0]   o_root
);
    logic [2*ROOTW-1:0] r_rad;
    logic [ROOTW-1:0]   r_root;
    logic [4:0]         r_bit;
    logic               r_sat;
    logic               r_busy;
    logic               r_done;
    logic [ROOTW-1:0]   cand;
    logic [2*ROOTW-1:0] cand_sq;

    assign cand    = r_root | (ROOTW'(1) << r_bit);
    assign cand_sq = (2*ROOTW)'(cand) * (2*ROOTW)'(cand);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == 5'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath; a radicand at or above 2^(2*ROOTW) saturates
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat  <= |i_radicand[RADW-1:2*ROOTW];
            r_rad  <= i_radicand[2*ROOTW-1:0];
            r_root <= '0;
            r_bit  <= 5'(ROOTW - 1);
        end else if (r_busy) begin
            if (cand_sq <= r_rad) r_root <= cand;
            r_bit <= r_bit - 5'd1;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_sat ? CW'(Q_MAX) : CW'(r_root);
endmodule
